>>> hdl/plen_pkg.sv
// shared types and constants for the positional list engine
package plen_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ID_BITS_DEF  = 16;

  localparam int FUNC_W  = 3;
  localparam int POS_W   = 7;
  localparam int SONG_W  = 16;
  localparam int STAT_W  = 3;
  localparam int FOUND_W = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_POS   = 3'd1,
    FN_INS_END   = 3'd2,
    FN_SEARCH    = 3'd3,
    FN_RM_FRONT  = 3'd4,
    FN_RM_POS    = 3'd5,
    FN_RM_END    = 3'd6,
    FN_CLEAR     = 3'd7
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_BADPOS   = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SEARCH
  } state_t;

  typedef enum logic [1:0] {
    K_NOW,
    K_UP,
    K_DN,
    K_SRCH
  } kind_t;

endpackage

>>> hdl/plen_ram.sv
// generic single-write, single-read ram with registered read data
module plen_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/positional_list_engine_core.sv
// positional list engine: ordered id list in ram with a one-entry-per-cycle shift sequencer
//
// An item is taken when start is high and busy is low; its result appears on the out_
// ports for one cycle with out_valid, and must be captured then. Clear, and any operation
// refused at once (full, empty, bad position), keeps busy low and answers in the next
// cycle. With count c, insert at position p keeps busy high while entries p to c-1 move
// up one place, remove at p while entries p+1 to c-1 move down one place, and search
// while entries are read in order up to the first match, or all c when there is none;
// the result is on the ports in the cycle busy drops. The sequence is set by the single ram
// port pair: each cycle reads one entry and writes back the one read the cycle before, so
// a search that misses in a full 64-entry list is the longest case.
module positional_list_engine_core
  import plen_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_BITS  = ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [POS_W-1:0]   in_position,
  input  logic [SONG_W-1:0]  in_song_id,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [FOUND_W-1:0] out_found_position,
  output logic [COUNT_W-1:0] out_item_count
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   tgt_r, tgt_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic               pend_r, pend_nxt;
  logic [ADDR_W-1:0]  pend_addr_r, pend_addr_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [FOUND_W-1:0] out_found_r, out_found_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  // decode of the offered item
  kind_t              dec_kind;
  status_t            dec_status;
  logic [CNT_W-1:0]   dec_ptr;
  logic [CNT_W-1:0]   dec_tgt;

  logic               accept;
  logic               full;
  logic               empty;
  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   cnt_x;
  logic [CNT_W-1:0]   ptr_m1;
  logic [CNT_W-1:0]   ptr_p1;
  logic [CNT_W-1:0]   cnt_p1;
  logic [CNT_W-1:0]   cnt_m1;

  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [ID_BITS-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [ID_BITS-1:0] ram_rd_data;

  logic               up_done;
  logic               dn_done;
  logic               match;
  logic               srch_done;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign full   = (cnt_r == CNT_W'(CAPACITY));
  assign empty  = (cnt_r == '0);
  assign pos_x  = CMP_W'(in_position);
  assign cnt_x  = CMP_W'(cnt_r);
  assign ptr_m1 = ptr_r - CNT_W'(1);
  assign ptr_p1 = ptr_r + CNT_W'(1);
  assign cnt_p1 = cnt_r + CNT_W'(1);
  assign cnt_m1 = cnt_r - CNT_W'(1);

  assign up_done   = (ptr_r == tgt_r) && !pend_r;
  assign dn_done   = (ptr_r == cnt_r) && !pend_r;
  assign match     = pend_r && (ram_rd_data == id_r);
  assign srch_done = match || ((ptr_r == cnt_r) && !pend_r);

  always_comb begin
    dec_kind   = K_NOW;
    dec_status = STAT_OK;
    dec_ptr    = '0;
    dec_tgt    = '0;
    case (func_t'(in_func))
      FN_INS_FRONT: begin
        if (full) begin
          dec_status = STAT_FULL;
        end else begin
          dec_kind = K_UP;
          dec_ptr  = cnt_r;
        end
      end
      FN_INS_POS: begin
        if (full) begin
          dec_status = STAT_FULL;
        end else if (pos_x == '0 || empty) begin
          dec_kind = K_UP;
          dec_ptr  = cnt_r;
        end else if (pos_x > cnt_x) begin
          dec_status = STAT_BADPOS;
        end else begin
          dec_kind = K_UP;
          dec_ptr  = cnt_r;
          dec_tgt  = CNT_W'(in_position);
        end
      end
      FN_INS_END: begin
        if (full) begin
          dec_status = STAT_FULL;
        end else begin
          dec_kind = K_UP;
          dec_ptr  = cnt_r;
          dec_tgt  = cnt_r;
        end
      end
      FN_SEARCH: begin
        if (empty) begin
          dec_status = STAT_EMPTY;
        end else begin
          dec_kind = K_SRCH;
        end
      end
      FN_RM_FRONT: begin
        if (empty) begin
          dec_status = STAT_EMPTY;
        end else begin
          dec_kind = K_DN;
          dec_ptr  = CNT_W'(1);
        end
      end
      FN_RM_POS: begin
        if (empty) begin
          dec_status = STAT_EMPTY;
        end else if (pos_x >= cnt_x) begin
          dec_status = STAT_BADPOS;
        end else begin
          dec_kind = K_DN;
          dec_ptr  = CNT_W'(in_position) + CNT_W'(1);
        end
      end
      FN_RM_END: begin
        if (empty) begin
          dec_status = STAT_EMPTY;
        end else begin
          dec_kind = K_DN;
          dec_ptr  = cnt_r;
        end
      end
      default: begin
        dec_status = STAT_OK;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (dec_kind)
            K_UP:    state_nxt = S_SHIFT_UP;
            K_DN:    state_nxt = S_SHIFT_DN;
            K_SRCH:  state_nxt = S_SEARCH;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SHIFT_UP: begin
        if (up_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT_DN: begin
        if (dn_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (srch_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, ram control and results
  always_comb begin
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    tgt_nxt        = tgt_r;
    id_nxt         = id_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = pend_addr_r;
    ram_wr_data    = ram_rd_data;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = ptr_r[ADDR_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ptr_nxt = dec_ptr;
          tgt_nxt = dec_tgt;
          id_nxt  = ID_BITS'(in_song_id);
          if (dec_kind == K_NOW) begin
            if (func_t'(in_func) == FN_CLEAR) begin
              cnt_nxt = '0;
            end
            out_valid_nxt  = 1'b1;
            out_status_nxt = dec_status;
            out_found_nxt  = '0;
            out_count_nxt  = (func_t'(in_func) == FN_CLEAR) ? '0 : COUNT_W'(cnt_r);
          end
        end
      end
      S_SHIFT_UP: begin
        // move entry ptr-1 up to ptr, then drop the new id into the gap
        if (pend_r) begin
          ram_wr_en = 1'b1;
        end else if (ptr_r == tgt_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = tgt_r[ADDR_W-1:0];
          ram_wr_data = id_r;
        end
        if (ptr_r > tgt_r) begin
          ram_rd_en     = 1'b1;
          ram_rd_addr   = ptr_m1[ADDR_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[ADDR_W-1:0];
          ptr_nxt       = ptr_m1;
        end
        if (up_done) begin
          cnt_nxt        = cnt_p1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_found_nxt  = '0;
          out_count_nxt  = COUNT_W'(cnt_p1);
        end
      end
      S_SHIFT_DN: begin
        // move entry ptr down to ptr-1
        if (pend_r) begin
          ram_wr_en = 1'b1;
        end
        if (ptr_r < cnt_r) begin
          ram_rd_en     = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_m1[ADDR_W-1:0];
          ptr_nxt       = ptr_p1;
        end
        if (dn_done) begin
          cnt_nxt        = cnt_m1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_found_nxt  = '0;
          out_count_nxt  = COUNT_W'(cnt_m1);
        end
      end
      S_SEARCH: begin
        if (ptr_r < cnt_r && !match) begin
          ram_rd_en     = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[ADDR_W-1:0];
          ptr_nxt       = ptr_p1;
        end
        if (srch_done) begin
          pend_nxt       = 1'b0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = match ? STAT_OK : STAT_NOTFOUND;
          out_found_nxt  = match ? FOUND_W'(CNT_W'(pend_addr_r)) : '0;
          out_count_nxt  = COUNT_W'(cnt_r);
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    tgt_r        <= tgt_nxt;
    id_r         <= id_nxt;
    pend_addr_r  <= pend_addr_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  plen_ram #(
    .WIDTH  (ID_BITS),
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_item_count     = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while sequencer busy");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && dec_kind == K_NOW) |=> (out_valid_r && state_r == S_IDLE))
    else $error("refused or clear item gave no result next cycle");

  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy)) |-> $stable(cnt_r))
    else $error("count changed mid operation");

  a_busy_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !up_done && !dn_done && !srch_done) |=> !out_valid_r)
    else $error("result strobe without finishing item");

endmodule
